@@ rtl/kch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kch_pkg
// Shared types and constants for the key click and hold detector.
// ----------------------------------------------------------------------------
package kch_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_LIMIT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RELOAD   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLICK_MAX       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_VALID      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LONG       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_EXTRA_LONG = 3'd5;

    localparam logic [7:0]  RST_DEBOUNCE_LIMIT  = 8'd20;
    localparam logic [15:0] RST_WINDOW_RELOAD   = 16'd300;
    localparam logic [3:0]  RST_CLICK_MAX       = 4'd3;
    localparam logic [7:0]  RST_HOLD_VALID      = 8'd2;
    localparam logic [7:0]  RST_HOLD_LONG       = 8'd8;
    localparam logic [7:0]  RST_HOLD_EXTRA_LONG = 8'd40;

    localparam logic [2:0] EVT_NONE       = 3'd0;
    localparam logic [2:0] EVT_CLICKS_MAX = 3'd3;
    localparam logic [2:0] EVT_LONG       = 3'd4;
    localparam logic [2:0] EVT_EXTRA_LONG = 3'd5;

    typedef struct packed {
        logic [7:0]  debounce_limit;
        logic [15:0] window_reload;
        logic [3:0]  click_max;
        logic [7:0]  hold_valid;
        logic [7:0]  hold_long;
        logic [7:0]  hold_extra_long;
    } kch_cfg_t;

    typedef struct packed {
        logic       key_down;
        logic [2:0] event_res;
    } kch_result_t;

    function automatic logic [2:0] click_code(input logic [7:0] n);
        logic [2:0] code;
        if (n > 8'd3) begin
            code = EVT_CLICKS_MAX;
        end else begin
            code = n[2:0];
        end
        return code;
    endfunction

endpackage
`default_nettype wire

@@ rtl/kch_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kch_cfg_regs
// Configuration register file written through the index/data write channel.
// ----------------------------------------------------------------------------
module kch_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kch_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kch_pkg::CFG_DATA_W-1:0]  cfg_data,
    output kch_pkg::kch_cfg_t                   cfg
);
    import kch_pkg::*;

    kch_cfg_t cfg_reg;
    kch_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DEBOUNCE_LIMIT:  cfg_next.debounce_limit  = cfg_data[7:0];
                REG_WINDOW_RELOAD:   cfg_next.window_reload   = cfg_data[15:0];
                REG_CLICK_MAX:       cfg_next.click_max       = cfg_data[3:0];
                REG_HOLD_VALID:      cfg_next.hold_valid      = cfg_data[7:0];
                REG_HOLD_LONG:       cfg_next.hold_long       = cfg_data[7:0];
                REG_HOLD_EXTRA_LONG: cfg_next.hold_extra_long = cfg_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_limit  <= RST_DEBOUNCE_LIMIT;
            cfg_reg.window_reload   <= RST_WINDOW_RELOAD;
            cfg_reg.click_max       <= RST_CLICK_MAX;
            cfg_reg.hold_valid      <= RST_HOLD_VALID;
            cfg_reg.hold_long       <= RST_HOLD_LONG;
            cfg_reg.hold_extra_long <= RST_HOLD_EXTRA_LONG;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/kch_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kch_core
// Debounce, click counting and hold detection, one sample per accepted request.
// ----------------------------------------------------------------------------
module kch_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic              key_level,
    input  wire logic              window_tick,
    input  wire logic              hold_tick,
    input  wire kch_pkg::kch_cfg_t cfg,
    output kch_pkg::kch_result_t   result
);
    import kch_pkg::*;

    logic        last_sample_reg,  last_sample_next;
    logic [7:0]  stable_count_reg, stable_count_next;
    logic        stable_level_reg, stable_level_next;
    logic [7:0]  click_count_reg,  click_count_next;
    logic [15:0] window_timer_reg, window_timer_next;
    logic [7:0]  hold_count_reg,   hold_count_next;
    logic [7:0]  hold_seen_reg,    hold_seen_next;
    logic        long_press_reg,   long_press_next;

    logic [15:0] wt_ticked;
    logic [7:0]  hc_ticked;
    logic [7:0]  cc_inc;
    logic [7:0]  click_max_ext;
    logic [2:0]  event_val;

    assign click_max_ext = {4'd0, cfg.click_max};

    always_comb begin
        wt_ticked = window_timer_reg;
        if (window_tick && (window_timer_reg != 16'd0)) begin
            wt_ticked = window_timer_reg - 16'd1;
        end
        hc_ticked = hold_count_reg;
        if (hold_tick && (hold_count_reg != 8'hFF)) begin
            hc_ticked = hold_count_reg + 8'd1;
        end
        cc_inc = click_count_reg;
        if (click_count_reg != 8'hFF) begin
            cc_inc = click_count_reg + 8'd1;
        end

        last_sample_next  = last_sample_reg;
        stable_count_next = stable_count_reg;
        stable_level_next = stable_level_reg;
        click_count_next  = click_count_reg;
        window_timer_next = wt_ticked;
        hold_count_next   = hc_ticked;
        hold_seen_next    = hold_seen_reg;
        long_press_next   = long_press_reg;
        event_val         = EVT_NONE;

        if (key_level == last_sample_reg) begin
            if (stable_count_reg >= cfg.debounce_limit) begin
                stable_level_next = last_sample_reg;
                if (last_sample_reg && !stable_level_reg) begin
                    if (long_press_reg) begin
                        long_press_next = 1'b0;
                    end else begin
                        click_count_next = cc_inc;
                        if (cc_inc == click_max_ext) begin
                            event_val = click_code(cc_inc);
                        end
                        window_timer_next = cfg.window_reload;
                    end
                end else if (wt_ticked == 16'd0) begin
                    if ((click_count_reg != 8'd0) && (click_count_reg < click_max_ext)) begin
                        event_val = click_code(click_count_reg);
                    end
                    click_count_next = 8'd0;
                end

                if (!last_sample_reg) begin
                    if (hold_seen_reg != hc_ticked) begin
                        if (hc_ticked == cfg.hold_extra_long) begin
                            event_val = EVT_EXTRA_LONG;
                        end else if (hc_ticked == cfg.hold_long) begin
                            event_val = EVT_LONG;
                        end else if (hc_ticked == cfg.hold_valid) begin
                            long_press_next = 1'b1;
                        end
                    end
                    hold_seen_next = hc_ticked;
                end else begin
                    hold_count_next = 8'd0;
                end
            end else begin
                stable_count_next = stable_count_reg + 8'd1;
            end
        end else begin
            stable_count_next = 8'd0;
            last_sample_next  = key_level;
        end

        result.event_res = event_val;
        result.key_down  = ~stable_level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sample_reg  <= 1'b0;
            stable_count_reg <= 8'd0;
            stable_level_reg <= 1'b0;
            click_count_reg  <= 8'd0;
            window_timer_reg <= 16'd0;
            hold_count_reg   <= 8'd0;
            hold_seen_reg    <= 8'd0;
            long_press_reg   <= 1'b0;
        end else if (step) begin
            last_sample_reg  <= last_sample_next;
            stable_count_reg <= stable_count_next;
            stable_level_reg <= stable_level_next;
            click_count_reg  <= click_count_next;
            window_timer_reg <= window_timer_next;
            hold_count_reg   <= hold_count_next;
            hold_seen_reg    <= hold_seen_next;
            long_press_reg   <= long_press_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/kch_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kch_out_buf
// Two-entry result register that decouples the input side from backpressure.
// ----------------------------------------------------------------------------
module kch_out_buf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire kch_pkg::kch_result_t push_data,
    output logic                     has_space,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output kch_pkg::kch_result_t     out_data
);
    import kch_pkg::*;

    kch_result_t ent0_reg, ent0_next;
    kch_result_t ent1_reg, ent1_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign pop       = out_valid && out_ready;
    assign has_space = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = ent0_reg;

    always_comb begin
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        count_next = count_reg;
        if (pop) begin
            ent0_next = ent1_reg;
        end
        if (push) begin
            if ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop)) begin
                ent0_next = push_data;
            end else begin
                ent1_next = push_data;
            end
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule
`default_nettype wire

@@ rtl/key_click_and_hold_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_click_and_hold_detector
// Debounces a raw active-low key sample and reports clicks and long presses.
// Each result is written into the output buffer when its request is accepted.
// Throughput: one request per cycle while the result buffer has space.
// A two-entry result buffer holds up to two results while m_tready is low.
// Reset: synchronous, active low; clears core state and the buffer count and loads register defaults.
// ----------------------------------------------------------------------------
module key_click_and_hold_detector (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: [0] key_level, [1] window_tick, [2] hold_tick, [7:3] zero
    input  wire logic [kch_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: [2:0] event_res, [3] key_down, [7:4] zero
    output logic [kch_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kch_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kch_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kch_pkg::*;

    kch_cfg_t    cfg;
    kch_result_t step_result;
    kch_result_t out_result;
    logic        accept;
    logic        buf_space;

    assign s_tready = buf_space;
    assign accept   = s_tvalid && buf_space;
    assign m_tdata  = {4'd0, out_result.key_down, out_result.event_res};

    kch_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kch_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .key_level   (s_tdata[0]),
        .window_tick (s_tdata[1]),
        .hold_tick   (s_tdata[2]),
        .cfg         (cfg),
        .result      (step_result)
    );

    kch_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (step_result),
        .has_space (buf_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

endmodule
`default_nettype wire

@@ tb/tb_key_click_and_hold_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_click_and_hold_detector
// Self-checking bench for the key click and hold detector. Key samples with
// window and hold ticks are streamed in under several register settings and
// handshake patterns, and every result is compared against a cycle-free
// predictor of the debounce, click counting and hold timing logic.
// ----------------------------------------------------------------------------
module tb_key_click_and_hold_detector;

    import kch_pkg::*;

    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 200;

    typedef struct packed {
        logic hold_tick;
        logic window_tick;
        logic key_level;
    } key_sample_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    key_sample_t sample_q[$];
    kch_result_t report_q[$];
    int          n_queued       = 0;
    int          n_accepted     = 0;
    int          err_cnt        = 0;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          wtick_pct      = 0;
    int          htick_pct      = 0;
    int          cur_deb        = 20;
    int          hold_off_seq   = 0;
    int          hold_off_seen  = 0;
    int          hold_off_left  = 0;
    logic        in_taken       = 1'b0;

    // Predictor state and register copy.
    kch_cfg_t    regs;
    logic        pin_last;
    logic [7:0]  settle_cnt;
    logic        level_up;
    logic [7:0]  click_tally;
    logic [15:0] window_left;
    logic [7:0]  hold_ticks;
    logic [7:0]  hold_mark;
    logic        hold_armed;

    key_click_and_hold_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_detector();
        regs.debounce_limit  = RST_DEBOUNCE_LIMIT;
        regs.window_reload   = RST_WINDOW_RELOAD;
        regs.click_max       = RST_CLICK_MAX;
        regs.hold_valid      = RST_HOLD_VALID;
        regs.hold_long       = RST_HOLD_LONG;
        regs.hold_extra_long = RST_HOLD_EXTRA_LONG;
        pin_last    = 1'b0;
        settle_cnt  = '0;
        level_up    = 1'b0;
        click_tally = '0;
        window_left = '0;
        hold_ticks  = '0;
        hold_mark   = '0;
        hold_armed  = 1'b0;
    endfunction

    function automatic void load_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DEBOUNCE_LIMIT:  regs.debounce_limit  = val[7:0];
            REG_WINDOW_RELOAD:   regs.window_reload   = val;
            REG_CLICK_MAX:       regs.click_max       = val[3:0];
            REG_HOLD_VALID:      regs.hold_valid      = val[7:0];
            REG_HOLD_LONG:       regs.hold_long       = val[7:0];
            REG_HOLD_EXTRA_LONG: regs.hold_extra_long = val[7:0];
            default: ;
        endcase
    endfunction

    // Three or more clicks share one code.
    function automatic logic [2:0] tally_code(logic [7:0] n);
        return (n > 8'd3) ? EVT_CLICKS_MAX : n[2:0];
    endfunction

    function automatic kch_result_t detect_step(key_sample_t smp);
        kch_result_t res;
        logic        was_up;
        res.event_res = EVT_NONE;
        if (smp.window_tick && window_left != 16'd0) begin
            window_left = window_left - 16'd1;
        end
        if (smp.hold_tick && hold_ticks != 8'hFF) begin
            hold_ticks = hold_ticks + 8'd1;
        end
        if (smp.key_level == pin_last) begin
            if (settle_cnt >= regs.debounce_limit) begin
                was_up   = level_up;
                level_up = pin_last;
                if (level_up && !was_up) begin
                    if (hold_armed) begin
                        hold_armed = 1'b0;
                    end else begin
                        if (click_tally != 8'hFF) begin
                            click_tally = click_tally + 8'd1;
                        end
                        if (click_tally == {4'd0, regs.click_max}) begin
                            res.event_res = tally_code(click_tally);
                        end
                        window_left = regs.window_reload;
                    end
                end else if (window_left == 16'd0) begin
                    if (click_tally > 8'd0 && click_tally < {4'd0, regs.click_max}) begin
                        res.event_res = tally_code(click_tally);
                    end
                    click_tally = '0;
                end
                if (!level_up) begin
                    if (hold_mark != hold_ticks) begin
                        if (hold_ticks == regs.hold_extra_long) begin
                            res.event_res = EVT_EXTRA_LONG;
                        end else if (hold_ticks == regs.hold_long) begin
                            res.event_res = EVT_LONG;
                        end else if (hold_ticks == regs.hold_valid) begin
                            hold_armed = 1'b1;
                        end
                    end
                    hold_mark = hold_ticks;
                end else begin
                    hold_ticks = '0;
                end
            end else begin
                settle_cnt = settle_cnt + 8'd1;
            end
        end else begin
            settle_cnt = '0;
            pin_last   = smp.key_level;
        end
        res.key_down = !level_up;
        return res;
    endfunction

    always @(posedge aclk) begin : monitor
        kch_result_t got;
        kch_result_t want;
        if (!aresetn) begin
            clear_detector();
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                load_reg(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                report_q.push_back(detect_step(key_sample_t'(s_tdata[2:0])));
                n_accepted++;
            end
            if (m_tvalid && m_tready) begin
                got = kch_result_t'(m_tdata[3:0]);
                if (report_q.size() == 0) begin
                    $error("unexpected result: m_tdata = %h", m_tdata);
                    err_cnt++;
                end else begin
                    want = report_q.pop_front();
                    if (got.event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
                        err_cnt++;
                    end
                    if (got.key_down !== want.key_down) begin
                        $error("key_down: expected %0d, got %0d", want.key_down, got.key_down);
                        err_cnt++;
                    end
                    if (m_tdata[7:4] !== 4'd0) begin
                        $error("m_tdata padding: expected 0, got %h", m_tdata[7:4]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin : sample_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= {5'd0, sample_q.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_left != 0) begin
            m_tready      <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else if (hold_off_seen != hold_off_seq) begin
            m_tready      <= 1'b0;
            hold_off_seen <= hold_off_seq;
            hold_off_left <= HOLD_OFF_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** key_click_and_hold_detector: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_sample(input logic key, input logic wt, input logic ht);
        key_sample_t smp;
        smp.key_level   = key;
        smp.window_tick = wt;
        smp.hold_tick   = ht;
        sample_q.push_back(smp);
        n_queued++;
    endtask

    task automatic queue_run(input logic key, input int len);
        for (int i = 0; i < len; i++) begin
            push_sample(key, $urandom_range(99) < wtick_pct, $urandom_range(99) < htick_pct);
        end
    endtask

    // Mostly clean press and release pairs, plus bounces and loose samples.
    task automatic queue_gestures(input int n_items, input int hold_span, input int gap_span);
        int target;
        int pick;
        target = n_queued + n_items;
        while (n_queued < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                queue_run(1'b0, cur_deb + 1 + $urandom_range(hold_span));
                queue_run(1'b1, cur_deb + 1 + $urandom_range(gap_span));
            end else if (pick < 85) begin
                queue_run(1'($urandom_range(1)), $urandom_range(cur_deb > 0 ? cur_deb : 1, 1));
            end else begin
                push_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (n_accepted != n_queued || report_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int deb, input int win, input int cmax,
                            input int hv, input int hl, input int hx);
        write_reg(REG_DEBOUNCE_LIMIT, deb);
        write_reg(REG_WINDOW_RELOAD, win);
        write_reg(REG_CLICK_MAX, cmax);
        write_reg(REG_HOLD_VALID, hv);
        write_reg(REG_HOLD_LONG, hl);
        write_reg(REG_HOLD_EXTRA_LONG, hx);
        cur_deb = deb;
    endtask

    task automatic set_traffic(input int send_pct, input int recv_pct,
                               input int wt_pct, input int ht_pct);
        @(posedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        wtick_pct      = wt_pct;
        htick_pct      = ht_pct;
    endtask

    initial begin : stimulus
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: the key reads as pressed until the released level
        // has settled, and that first release counts as a click.
        set_traffic(0, 0, 0, 0);
        for (int i = 0; i < 4; i++) begin
            push_sample(1'b0, i[0], i[1]);
        end
        for (int i = 0; i < 22; i++) begin
            push_sample(1'b1, i[0], i[1]);
        end
        wait_drained();

        set_regs(1, 8, 3, 2, 5, 9);
        set_traffic(0, 0, 40, 60);
        queue_gestures(120, 20, 12);
        wait_drained();

        // Lowest settings: every hold threshold equal at zero.
        set_regs(0, 0, 1, 0, 0, 0);
        set_traffic(49, 0, 50, 50);
        queue_gestures(80, 6, 6);
        wait_drained();

        // Click maximum of zero, equal hold thresholds, and a long receiver
        // hold-off while samples keep coming.
        set_regs(3, 20, 0, 4, 4, 4);
        set_traffic(0, 49, 40, 50);
        hold_off_seq++;
        queue_gestures(120, 12, 50);
        wait_drained();

        // Fast clicks without window ticks drive the click count to saturation.
        set_regs(0, 65535, 15, 200, 250, 254);
        set_traffic(12, 12, 0, 0);
        for (int i = 0; i < 258; i++) begin
            push_sample(1'b0, 1'b0, 1'b0);
            push_sample(1'b0, 1'b0, 1'b0);
            push_sample(1'b1, 1'b0, 1'b0);
            push_sample(1'b1, 1'b0, 1'b0);
        end
        wait_drained();

        // Highest settings: the hold count saturates before the press settles.
        set_regs(255, 65535, 15, 255, 255, 255);
        set_traffic(0, 0, 0, 100);
        queue_run(1'b0, 260);
        set_traffic(0, 0, 0, 0);
        queue_run(1'b1, 258);
        wait_drained();

        if (report_q.size() != 0) begin
            $error("%0d expected results never arrived", report_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("** key_click_and_hold_detector: PASSED **");
        end else begin
            $display("** key_click_and_hold_detector: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kch_pkg.sv
rtl/kch_cfg_regs.sv
rtl/kch_core.sv
rtl/kch_out_buf.sv
rtl/key_click_and_hold_detector.sv
tb/tb_key_click_and_hold_detector.sv
